// ===== design/skf_pkg.sv =====
// skf_pkg: shared types and constants for the scalar Kalman filter.
// Used by skf_ctrl, skf_datapath, scalar_kalman_filter and skf_checker. No dependencies.
`timescale 1ns / 1ps

package skf_pkg;

  localparam int FRAC_BITS            = 16;
  localparam int EST_W                = 32;
  localparam int VAR_W                = 32;
  localparam int NOISE_W              = 32;
  localparam int GAIN_W               = 17;
  localparam int CFG_IDX_W            = 1;
  localparam int DEFAULT_SAMPLE_WIDTH = 16;

  // Divider: one integer quotient bit plus FRAC_BITS fraction bits
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [GAIN_W-1:0]  GAIN_ONE     = GAIN_W'(1 << FRAC_BITS);
  localparam logic [VAR_W-1:0]   VAR_RESET    = VAR_W'(1 << FRAC_BITS);
  localparam logic [NOISE_W-1:0] PNOISE_RESET = NOISE_W'(655);
  localparam logic [NOISE_W-1:0] MNOISE_RESET = NOISE_W'(1 << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_NOISE = 1'b0,
    REG_MEASURE_NOISE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_DIV,
    S_MUL,
    S_UPD
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch sample, form predicted variance
    logic init;    // form denominator, difference, seed remainder
    logic step;    // one restoring division step
    logic first;   // first step: compare without shifting
    logic mult;    // register both products
    logic update;  // commit estimate, variance, gain output
  } skf_cmd_t;

endpackage

// ===== design/skf_ctrl.sv =====
// skf_ctrl: sequencer for the scalar Kalman filter and the output valid flag.
// Depends on skf_pkg.
`timescale 1ns / 1ps

module skf_ctrl
  import skf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output skf_cmd_t cmd
);

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] cnt, cnt_next;
  logic                 out_valid_next;
  logic                 upd_fire;

  assign upd_fire = (state == S_UPD) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_INIT;
      end
      S_INIT: begin
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = S_MUL;
      end
      S_MUL: state_next = S_UPD;
      S_UPD: begin
        if (upd_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_INIT: cmd.init = 1'b1;
      S_DIV: begin
        cmd.step  = 1'b1;
        cmd.first = (cnt == '0);
      end
      S_MUL: cmd.mult = 1'b1;
      S_UPD: begin
        cmd.update = upd_fire;
        if (upd_fire) out_valid_next = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/skf_datapath.sv =====
// skf_datapath: noise registers, filter state, serial gain divider and multipliers.
// Depends on skf_pkg; driven by skf_ctrl commands.
`timescale 1ns / 1ps

module skf_datapath
  import skf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  skf_cmd_t                      cmd,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [NOISE_W-1:0]            cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] measurement,
  output logic signed [EST_W-1:0]       estimate_out,
  output logic [GAIN_W-1:0]             gain_out
);

  localparam int MEAS_W = SAMPLE_WIDTH + FRAC_BITS;
  localparam int DIFF_W = ((MEAS_W > EST_W) ? MEAS_W : EST_W) + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam int NEXT_W = DIFF_W + 1;
  localparam int VPROD_W = GAIN_W + VAR_W;

  logic [NOISE_W-1:0]             process_noise, measure_noise;
  logic signed [EST_W-1:0]        estimate;
  logic [VAR_W-1:0]               variance;

  logic signed [SAMPLE_WIDTH-1:0] meas_r;
  logic [VAR_W-1:0]               ppred;
  logic [VAR_W:0]                 ppred_sum;
  logic [VAR_W:0]                 denom;
  logic [VAR_W+1:0]               rem, rem_next, trial;
  logic                           trial_ge;
  logic [GAIN_W-1:0]              quo;
  logic                           zero_den;
  logic signed [DIFF_W-1:0]       diff;
  logic signed [MEAS_W-1:0]       meas_q;
  logic [GAIN_W-1:0]              gain;
  logic signed [PROD_W-1:0]       prod_est;
  logic [VPROD_W-1:0]             prod_var;
  logic signed [NEXT_W-1:0]       est_sum;
  logic [NEXT_W-EST_W:0]          est_top;
  logic signed [EST_W-1:0]        est_sat;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= PNOISE_RESET;
      measure_noise <= MNOISE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROCESS_NOISE: process_noise <= cfg_data;
        REG_MEASURE_NOISE: measure_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ppred_sum = {1'b0, variance} + {1'b0, process_noise};
  assign meas_q    = {meas_r, FRAC_BITS'(0)};

  // restoring division step
  assign trial    = cmd.first ? rem : {rem[VAR_W:0], 1'b0};
  assign trial_ge = trial >= {1'b0, denom};
  assign rem_next = trial_ge ? trial - {1'b0, denom} : trial;

  // saturate the new estimate to 32 bits
  assign est_sum = NEXT_W'(estimate) + NEXT_W'(prod_est >>> FRAC_BITS);
  assign est_top = est_sum[NEXT_W-1:EST_W-1];
  always_comb begin
    if ((&est_top) || !(|est_top)) est_sat = est_sum[EST_W-1:0];
    else if (est_sum[NEXT_W-1])    est_sat = {1'b1, {(EST_W-1){1'b0}}};
    else                           est_sat = {1'b0, {(EST_W-1){1'b1}}};
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas_r <= measurement;
      ppred  <= ppred_sum[VAR_W] ? '1 : ppred_sum[VAR_W-1:0];
    end
    if (cmd.init) begin
      denom    <= {1'b0, ppred} + {1'b0, measure_noise};
      zero_den <= (ppred == '0) && (measure_noise == '0);
      rem      <= (VAR_W+2)'(ppred);
      diff     <= DIFF_W'(meas_q) - DIFF_W'(estimate);
    end
    if (cmd.step) begin
      rem <= rem_next;
      quo <= {quo[GAIN_W-2:0], trial_ge};
    end
    if (cmd.mult) begin
      gain     <= zero_den ? GAIN_ONE : quo;
      prod_est <= PROD_W'(signed'({1'b0, zero_den ? GAIN_ONE : quo})) * PROD_W'(diff);
      prod_var <= VPROD_W'(GAIN_ONE - (zero_den ? GAIN_ONE : quo)) * VPROD_W'(ppred);
    end
    if (cmd.update) gain_out <= gain;
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate <= '0;
      variance <= VAR_RESET;
    end else if (cmd.update) begin
      estimate <= est_sat;
      variance <= prod_var[FRAC_BITS +: VAR_W];
    end
  end

  // the estimate only moves when a result is handed to the output
  assign estimate_out = estimate;

endmodule

// ===== design/scalar_kalman_filter.sv =====
// scalar_kalman_filter: top level, one-dimensional Kalman filter in fixed point.
// Instantiates skf_ctrl and skf_datapath; depends on skf_pkg.
//
// Usage:
//   Input channel: measurement (signed integer sample), in_valid / in_ready.
//   Output channel: estimate_out (signed Q16.16) and gain_out (Q1.16, 65536
//   is one), out_valid / out_ready. One result per sample, in order.
//   Config port: cfg_write / cfg_index / cfg_data; index 0 is the process
//   noise Q, index 1 the measurement noise R, both unsigned Q16.16. Write
//   only while the filter is idle.
//   Sequence: the predicted variance is latched at the input transaction,
//   then come the setup step, the bit-serial gain divider steps, the
//   multiply and the update, after which out_valid rises. A new sample
//   is taken only once the sequencer is back in idle.
//   in_ready is high only while the sequencer is idle, so one sample is in
//   flight at a time; a new sample is taken while a result still waits.
//   Stall: a finished result sits in the output register; if it is not yet
//   taken, the next sample waits at its update step until it is.
//   Reset (rst, synchronous): estimate 0, variance 1.0, Q 655, R 1.0, both
//   channels empty.
`timescale 1ns / 1ps

module scalar_kalman_filter
  import skf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic signed [SAMPLE_WIDTH-1:0] measurement,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic signed [EST_W-1:0]        estimate_out,
  output logic [GAIN_W-1:0]              gain_out,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           cfg_write,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [NOISE_W-1:0]             cfg_data
);

  skf_cmd_t cmd;

  // sequencer: predict, setup, divide, multiply, update
  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic and state; estimate register doubles as the output register
  skf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .measurement  (measurement),
    .estimate_out (estimate_out),
    .gain_out     (gain_out)
  );

endmodule

// ===== design/skf_checker.sv =====
// skf_assertions: port-level assertions for scalar_kalman_filter, plus its bind.
// Depends on skf_pkg.
`timescale 1ns / 1ps

module skf_assertions
  import skf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [EST_W-1:0]  estimate_out,
  input logic [GAIN_W-1:0] gain_out,
  input logic              out_valid,
  input logic              out_ready
);

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(estimate_out) && $stable(gain_out))
    else $error("result changed while stalled");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gain_out <= GAIN_ONE)
    else $error("gain above one");

  // one sample in flight: busy right after an input transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_reset: assert property (@(posedge clk)
    $fell(rst) |-> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind scalar_kalman_filter skf_assertions u_skf_assertions (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .estimate_out (estimate_out),
  .gain_out     (gain_out),
  .out_valid    (out_valid),
  .out_ready    (out_ready)
);
